// ===== rtl/core/sld_pkg.sv =====
// Shared types and constants for the start-of-frame / length / checksum deframer.
// Holds the parser phase encoding, the result kind codes and the result struct.
// Depends on nothing; imported by sld_parser and sof_length_checksum_deframer.
`timescale 1ns / 1ps

package sld_pkg;

    localparam int BYTE_W = 8;
    localparam logic [BYTE_W-1:0] START_RESET = 8'hAA;

    typedef enum logic [1:0] {
        PHASE_HUNT    = 2'd0,
        PHASE_LEN     = 2'd1,
        PHASE_PAYLOAD = 2'd2,
        PHASE_SUM     = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_GOOD = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    typedef struct packed {
        logic              has_result;
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] err;
    } t_result;

endpackage

// ===== rtl/core/sld_parser.sv =====
// Frame parser state machine: phase, length, byte count, running sum, error count.
// Computes the result for the presented byte and updates its state on a step.
// Depends on sld_pkg.
`timescale 1ns / 1ps

module sld_parser
    import sld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [BYTE_W-1:0] i_start_byte,
    output t_result           o_res
);

    t_phase            r_phase;
    t_phase            n_phase;
    logic [BYTE_W-1:0] r_frame_len;
    logic [BYTE_W-1:0] n_frame_len;
    logic [BYTE_W-1:0] r_count;
    logic [BYTE_W-1:0] n_count;
    logic [BYTE_W-1:0] r_sum;
    logic [BYTE_W-1:0] n_sum;
    logic [BYTE_W-1:0] r_err;
    logic [BYTE_W-1:0] n_err;
    logic [BYTE_W-1:0] w_count_inc;
    logic [BYTE_W-1:0] w_err_inc;
    logic              w_sum_ok;

    assign w_count_inc = r_count + 8'd1;
    assign w_err_inc   = r_err + 8'd1;
    assign w_sum_ok    = (r_sum == i_byte);

    always_comb begin
        n_phase     = r_phase;
        n_frame_len = r_frame_len;
        n_count     = r_count;
        n_sum       = r_sum;
        n_err       = r_err;
        unique case (r_phase)
            PHASE_HUNT: begin
                if (i_byte == i_start_byte) begin
                    n_sum   = i_byte;
                    n_phase = PHASE_LEN;
                end
            end
            PHASE_LEN: begin
                n_frame_len = i_byte;
                n_count     = '0;
                n_sum       = r_sum + i_byte;
                n_phase     = (i_byte == '0) ? PHASE_SUM : PHASE_PAYLOAD;
            end
            PHASE_PAYLOAD: begin
                n_count = w_count_inc;
                n_sum   = r_sum + i_byte;
                if (w_count_inc == r_frame_len) begin
                    n_phase = PHASE_SUM;
                end
            end
            PHASE_SUM: begin
                n_phase = PHASE_HUNT;
                if (!w_sum_ok) begin
                    n_err = w_err_inc;
                end
            end
        endcase
    end

    always_comb begin
        o_res.has_result = 1'b0;
        o_res.kind       = KIND_DATA;
        o_res.data       = '0;
        o_res.len        = r_frame_len;
        o_res.err        = r_err;
        unique case (r_phase)
            PHASE_HUNT, PHASE_LEN: begin
                o_res.has_result = 1'b0;
            end
            PHASE_PAYLOAD: begin
                o_res.has_result = 1'b1;
                o_res.data       = i_byte;
            end
            PHASE_SUM: begin
                o_res.has_result = 1'b1;
                if (w_sum_ok) begin
                    o_res.kind = KIND_GOOD;
                end else begin
                    o_res.kind = KIND_BAD;
                    o_res.err  = w_err_inc;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PHASE_HUNT;
            r_frame_len <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_err       <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_frame_len <= n_frame_len;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_err       <= n_err;
        end
    end

    a_payload_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PHASE_PAYLOAD) |-> (r_count != r_frame_len))
        else $error("payload count reached frame length while still in payload");

    a_zero_len_skips_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_phase == PHASE_LEN && i_byte == '0) |=> (r_phase == PHASE_SUM))
        else $error("zero-length frame did not go straight to checksum");

    a_error_only_on_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !(r_phase == PHASE_SUM && !w_sum_ok)) |=> $stable(r_err))
        else $error("error count moved without a checksum failure");

endmodule

// ===== rtl/core/sof_length_checksum_deframer.sv =====
// Deframer for start byte / length / payload / additive checksum frames.
// Bytes pass the input register, results the result register. Throughput: one byte
// per cycle unless i_ready stalls; the input and result registers run back to back.
// A byte that gives no result retires without waiting for the output side.
// Reset (synchronous, active low) empties both stages, returns the parser to the hunt
// and sets the start byte to 0xAA. Depends on sld_pkg and sld_parser.
`timescale 1ns / 1ps

module sof_length_checksum_deframer
    import sld_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [BYTE_W-1:0] i_cfg_wdata,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_out_kind,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic [BYTE_W-1:0] o_out_len,
    output logic [BYTE_W-1:0] o_error_total
);

    logic [BYTE_W-1:0] r_start_byte;
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_kind             r_kind;
    logic [BYTE_W-1:0] r_byte;
    logic [BYTE_W-1:0] r_len;
    logic [BYTE_W-1:0] r_err;
    t_result           w_res;
    logic              w_out_free;
    logic              w_advance;
    logic              w_load;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_advance  = r_in_valid && (w_out_free || !w_res.has_result);
    assign w_load     = w_advance && w_res.has_result;
    assign o_ready    = !r_in_valid || w_advance;

    sld_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (w_advance),
        .i_byte       (r_in_byte),
        .i_start_byte (r_start_byte),
        .o_res        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte <= START_RESET;
        end else if (i_cfg_we) begin
            r_start_byte <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_kind <= w_res.kind;
            r_byte <= w_res.data;
            r_len  <= w_res.len;
            r_err  <= w_res.err;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_kind    = r_kind;
    assign o_out_byte    = r_byte;
    assign o_out_len     = r_len;
    assign o_error_total = r_err;

    a_stalled_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input byte was lost or changed");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |-> !w_load)
        else $error("result register overwritten while waiting");

    a_status_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind != KIND_DATA) |-> (r_byte == '0))
        else $error("frame status result carries a nonzero byte");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_kind == KIND_DATA || r_kind == KIND_GOOD || r_kind == KIND_BAD))
        else $error("result kind out of range");

endmodule
